/* rtl/ecc_pkg.sv */
// Shared types and constants for the elevator car controller.
package ecc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ELAPSED_W  = 16;
	localparam int FLOOR_W    = 6;
	localparam int LOAD_W     = 5;
	localparam int CAP_W      = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIME = 2'd3;

	localparam logic [CAP_W-1:0]     CAPACITY_RST    = 5'd8;
	localparam logic [FLOOR_W-1:0]   TOP_FLOOR_RST   = 6'd16;
	localparam logic [ELAPSED_W-1:0] IDLE_LIMIT_RST  = 16'd1000;
	localparam logic [ELAPSED_W-1:0] TRAVEL_TIME_RST = 16'd100;
	localparam logic [FLOOR_W-1:0]   FLOOR_GROUND    = 6'd1;

	typedef enum logic [1:0] {
		REQ_ADD,
		REQ_SET_STATE,
		REQ_IDLE_ADV,
		REQ_MOVE_ADV
	} req_type_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_UP,
		CS_DOWN,
		CS_STOPPED
	} car_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [FLOOR_W-1:0]   target_floor;
		logic [1:0]           new_state;
		logic [ELAPSED_W-1:0] elapsed;
	} in_item_t;

	typedef struct packed {
		logic               accepted;
		logic [FLOOR_W-1:0] floor;
		logic [LOAD_W-1:0]  load;
		logic [1:0]         car_state;
		logic               arrived;
	} out_item_t;

endpackage

/* rtl/ecc_ram.sv */
// Generic single-port-write, registered-read RAM.
module ecc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/ecc_tmr_unit.sv */
// Shared timer unit: saturating add of elapsed ticks and limit compare.
module ecc_tmr_unit #(
	parameter int TIME_BITS = 16
) (
	input  logic [TIME_BITS:0]            acc,
	input  logic [ecc_pkg::ELAPSED_W-1:0] elapsed,
	input  logic [ecc_pkg::ELAPSED_W-1:0] limit,
	output logic [TIME_BITS:0]            sum,
	output logic                          reached
);
	import ecc_pkg::*;

	localparam int TB = TIME_BITS + 1;
	localparam int SW = (TB > ELAPSED_W ? TB : ELAPSED_W) + 1;
	localparam logic [SW-1:0] SAT_W = {{(SW-TB){1'b0}}, {TB{1'b1}}};

	logic [SW-1:0] sum_w;

	always_comb begin
		sum_w   = SW'(acc) + SW'(elapsed);
		sum     = (sum_w > SAT_W) ? {TB{1'b1}} : sum_w[TB-1:0];
		reached = SW'(sum) >= SW'(limit);
	end

endmodule

/* rtl/elevator_car_controller.sv */
// Elevator car controller top level: sequencer, car state, rider table.
// Steps, accept to result valid: set-state, idle advance, refused add and a movement
//   advance without a floor tick go from exec straight to emit; an add scans to the
//   first free slot; a movement advance that completes a floor time scans the table
//   and drains before emit. Throughput: one item at a time, back in idle once emitted;
//   the rider table scan reads one entry per cycle through the single RAM read port,
//   and a result still waiting in the output register holds the next one back.
// Reset (arst_n, async): floor 1, idle, timers 0, all riders invalid, registers to
//   defaults; rider targets are not cleared (valid bits gate every read).
module elevator_car_controller #(
	parameter int MAX_RIDERS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ecc_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ecc_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [ecc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ecc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import ecc_pkg::*;

	localparam int TB = TIME_BITS + 1;
	localparam int IW = (MAX_RIDERS > 1) ? $clog2(MAX_RIDERS) : 1;
	localparam int LW = $clog2(MAX_RIDERS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_RIDERS - 1);

	// configuration
	logic [CAP_W-1:0]     cap_q;
	logic [FLOOR_W-1:0]   top_q;
	logic [ELAPSED_W-1:0] idle_lim_q;
	logic [ELAPSED_W-1:0] trav_time_q;

	// sequencer and car state
	seq_state_t           state_q, state_d;
	in_item_t             req_q;
	logic [FLOOR_W-1:0]   floor_q;
	logic [FLOOR_W-1:0]   floor_next;
	car_state_t           mode_q;
	logic [TB-1:0]        idle_cnt_q;
	logic [TB-1:0]        trav_cnt_q;
	logic [MAX_RIDERS-1:0] rider_valid_q;
	logic [LW-1:0]        load_q;
	logic [IW-1:0]        scan_q;
	logic                 drop_q;
	logic                 hit_q;
	logic                 acc_q;
	logic                 arr_q;

	// drop scan: RAM read issued in ST_SCAN, checked in the cycle after
	logic                 chk_s1;
	logic [IW-1:0]        idx_s1;
	logic [FLOOR_W-1:0]   ram_rdata;
	logic                 ram_we;
	logic                 hit_now;

	logic                 out_valid_q;
	out_item_t            out_item_q;

	// shared timer unit
	logic [TB-1:0]        tmr_acc;
	logic [ELAPSED_W-1:0] tmr_lim;
	logic [TB-1:0]        tmr_sum;
	logic                 tmr_reached;

	logic                 room;
	logic                 emit_go;

	assign tmr_acc = (req_q.req_type == REQ_IDLE_ADV) ? idle_cnt_q : trav_cnt_q;
	assign tmr_lim = (req_q.req_type == REQ_IDLE_ADV) ? idle_lim_q : trav_time_q;

	ecc_tmr_unit #(
		.TIME_BITS(TIME_BITS)
	) u_tmr (
		.acc    (tmr_acc),
		.elapsed(req_q.elapsed),
		.limit  (tmr_lim),
		.sum    (tmr_sum),
		.reached(tmr_reached)
	);

	// add scan writes the first free slot it meets
	assign ram_we = (state_q == ST_SCAN) && !drop_q && !rider_valid_q[scan_q];

	ecc_ram #(
		.WIDTH(FLOOR_W),
		.DEPTH(MAX_RIDERS)
	) u_targets (
		.clk  (clk),
		.we   (ram_we),
		.waddr(scan_q),
		.wdata(req_q.target_floor),
		.raddr(scan_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		room    = (32'(load_q) < 32'(cap_q)) && (32'(load_q) < MAX_RIDERS);
		hit_now = chk_s1 && rider_valid_q[idx_s1] && (ram_rdata == floor_q);
		emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		// one floor step, clamped at ground and top
		if (mode_q == CS_UP && floor_q < top_q) begin
			floor_next = floor_q + 6'd1;
		end else if (mode_q == CS_DOWN && floor_q > FLOOR_GROUND) begin
			floor_next = floor_q - 6'd1;
		end else begin
			floor_next = floor_q;
		end
	end

	// next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (req_type_t'(req_q.req_type))
					REQ_ADD:      state_d = room ? ST_SCAN : ST_EMIT;
					REQ_MOVE_ADV: state_d = tmr_reached ? ST_SCAN : ST_EMIT;
					default:      state_d = ST_EMIT;
				endcase
			end
			ST_SCAN: begin
				if (drop_q) begin
					if (scan_q == LAST_IDX) state_d = ST_DRAIN;
				end else if (!rider_valid_q[scan_q]) begin
					state_d = ST_EMIT;
				end
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers; the user must write them only while the car is quiet, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAPACITY_RST;
			top_q       <= TOP_FLOOR_RST;
			idle_lim_q  <= IDLE_LIMIT_RST;
			trav_time_q <= TRAVEL_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CAPACITY:    cap_q       <= cfg_wdata[CAP_W-1:0];
				CFG_TOP_FLOOR:   top_q       <= cfg_wdata[FLOOR_W-1:0];
				CFG_IDLE_LIMIT:  idle_lim_q  <= cfg_wdata[ELAPSED_W-1:0];
				CFG_TRAVEL_TIME: trav_time_q <= cfg_wdata[ELAPSED_W-1:0];
				default: ;
			endcase
		end
	end

	// car datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q         <= '0;
			floor_q       <= FLOOR_GROUND;
			mode_q        <= CS_IDLE;
			idle_cnt_q    <= '0;
			trav_cnt_q    <= '0;
			rider_valid_q <= '0;
			load_q        <= '0;
			scan_q        <= '0;
			drop_q        <= 1'b0;
			hit_q         <= 1'b0;
			acc_q         <= 1'b0;
			arr_q         <= 1'b0;
			chk_s1        <= 1'b0;
			idx_s1        <= '0;
		end else begin
			chk_s1 <= (state_q == ST_SCAN) && drop_q;
			idx_s1 <= scan_q;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q  <= in_item;
						acc_q  <= 1'b0;
						arr_q  <= 1'b0;
						hit_q  <= 1'b0;
						drop_q <= 1'b0;
						scan_q <= '0;
					end
				end
				ST_EXEC: begin
					case (req_type_t'(req_q.req_type))
						REQ_ADD: drop_q <= 1'b0;
						REQ_SET_STATE: begin
							mode_q <= car_state_t'(req_q.new_state);
							if (car_state_t'(req_q.new_state) != CS_IDLE) idle_cnt_q <= '0;
						end
						REQ_IDLE_ADV: begin
							if (mode_q == CS_IDLE) begin
								idle_cnt_q <= tmr_reached ? '0 : tmr_sum;
								if (tmr_reached && floor_q != FLOOR_GROUND) mode_q <= CS_DOWN;
							end
						end
						REQ_MOVE_ADV: begin
							trav_cnt_q <= tmr_reached ? '0 : tmr_sum;
							if (tmr_reached) begin
								floor_q <= floor_next;
								drop_q  <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_SCAN: begin
					if (!drop_q && !rider_valid_q[scan_q]) begin
						rider_valid_q[scan_q] <= 1'b1;
						load_q                <= load_q + LW'(1);
						acc_q                 <= 1'b1;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (hit_q || hit_now) begin
						mode_q     <= CS_STOPPED;
						idle_cnt_q <= '0;
						arr_q      <= 1'b1;
					end
				end
				default: ;
			endcase

			// drop check comes in the cycle after the read; never overlaps an add
			if (hit_now) begin
				rider_valid_q[idx_s1] <= 1'b0;
				load_q                <= load_q - LW'(1);
				hit_q                 <= 1'b1;
			end
		end
	end

	// output register: holds the result while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else if (emit_go) begin
			out_valid_q          <= 1'b1;
			out_item_q.accepted  <= acc_q;
			out_item_q.floor     <= floor_q;
			out_item_q.load      <= LOAD_W'(load_q);
			out_item_q.car_state <= mode_q;
			out_item_q.arrived   <= arr_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// load counter tracks the valid bits exactly
	a_load_matches: assert property (@(posedge clk) disable iff (!arst_n)
		32'(load_q) == $countones(rider_valid_q))
		else $error("load count out of step with rider valid bits");

	// an add scan only runs when a free slot exists
	a_add_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !drop_q) |-> !(&rider_valid_q))
		else $error("add scan with a full rider table");

	// the car never leaves the valid floor range at the bottom
	a_floor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		floor_q != '0)
		else $error("car on floor zero");

	// an arrival always reports a stopped car
	a_arrived_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.arrived) |-> (out_item.car_state == CS_STOPPED))
		else $error("arrival without stopped state");

endmodule

/* tb/tb_elevator_car_controller.sv */
// Testbench for the elevator car controller: a scoreboard with its own car model, driven stimulus.
`timescale 1ns / 100ps

module tb_elevator_car_controller;
	import ecc_pkg::*;

	localparam int RIDERS          = 16;
	localparam int TIME_BITS       = 16;
	localparam int TIMER_W         = TIME_BITS + 1;
	localparam int IN_W            = $bits(in_item_t);
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 125;
	// slowest item is a floor tick with a full table scan
	localparam int DRAIN_CYCLES    = 4 * (RIDERS + 4);
	localparam int CYCLE_LIMIT     = 600000;

	// Scoreboard: keeps its own copy of the car and the registers, predicts the
	// status item for every accepted request and checks results in order.
	class car_scoreboard;
		logic [CAP_W-1:0]     capacity;
		logic [FLOOR_W-1:0]   top_floor;
		logic [ELAPSED_W-1:0] idle_limit;
		logic [ELAPSED_W-1:0] travel_time;
		logic [FLOOR_W-1:0]   floor_now;
		car_state_t           mode;
		logic [TIMER_W-1:0]   idle_ticks;
		logic [TIMER_W-1:0]   travel_ticks;
		logic [FLOOR_W-1:0]   dest [RIDERS];
		bit                   aboard [RIDERS];
		out_item_t            status_q [$];
		int                   errors;

		function new();
			capacity     = CAPACITY_RST;
			top_floor    = TOP_FLOOR_RST;
			idle_limit   = IDLE_LIMIT_RST;
			travel_time  = TRAVEL_TIME_RST;
			floor_now    = FLOOR_GROUND;
			mode         = CS_IDLE;
			idle_ticks   = '0;
			travel_ticks = '0;
			for (int i = 0; i < RIDERS; i++) begin
				dest[i]   = '0;
				aboard[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			CFG_CAPACITY:    capacity    = data[CAP_W-1:0];
			CFG_TOP_FLOOR:   top_floor   = data[FLOOR_W-1:0];
			CFG_IDLE_LIMIT:  idle_limit  = data[ELAPSED_W-1:0];
			CFG_TRAVEL_TIME: travel_time = data[ELAPSED_W-1:0];
			default: ;
			endcase
		endfunction

		function int riders_aboard();
			int n;
			n = 0;
			for (int i = 0; i < RIDERS; i++)
				if (aboard[i])
					n++;
			return n;
		endfunction

		// timers saturate one bit above the elapsed width
		function logic [TIMER_W-1:0] add_ticks(logic [TIMER_W-1:0] acc,
				logic [ELAPSED_W-1:0] el);
			logic [TIMER_W:0] s;
			s = {1'b0, acc} + el;
			return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
		endfunction

		function void note_request(in_item_t it);
			out_item_t st;
			int        n;
			bit        hit;
			st = '0;
			case (req_type_t'(it.req_type))
			REQ_ADD: begin
				n = riders_aboard();
				if (n < capacity && n < RIDERS) begin
					for (int i = 0; i < RIDERS; i++) begin
						if (!aboard[i] && !st.accepted) begin
							aboard[i]   = 1'b1;
							dest[i]     = it.target_floor;
							st.accepted = 1'b1;
						end
					end
				end
			end
			REQ_SET_STATE: begin
				mode = car_state_t'(it.new_state);
				if (mode != CS_IDLE)
					idle_ticks = '0;
			end
			REQ_IDLE_ADV: begin
				if (mode == CS_IDLE) begin
					idle_ticks = add_ticks(idle_ticks, it.elapsed);
					if (idle_ticks >= idle_limit) begin
						if (floor_now != FLOOR_GROUND)
							mode = CS_DOWN;
						idle_ticks = '0;
					end
				end
			end
			REQ_MOVE_ADV: begin
				travel_ticks = add_ticks(travel_ticks, it.elapsed);
				if (travel_ticks >= travel_time) begin
					travel_ticks = '0;
					if (mode == CS_UP && floor_now < top_floor)
						floor_now = floor_now + 1'b1;
					else if (mode == CS_DOWN && floor_now > FLOOR_GROUND)
						floor_now = floor_now - 1'b1;
					hit = 1'b0;
					for (int i = 0; i < RIDERS; i++) begin
						if (aboard[i] && dest[i] == floor_now) begin
							hit       = 1'b1;
							aboard[i] = 1'b0;
						end
					end
					if (hit) begin
						mode       = CS_STOPPED;
						idle_ticks = '0;
						st.arrived = 1'b1;
					end
				end
			end
			default: ;
			endcase
			st.floor     = floor_now;
			st.load      = LOAD_W'(riders_aboard());
			st.car_state = mode;
			status_q     = {status_q, st};
		endfunction

		function void check_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_status(out_item_t got);
			out_item_t want;
			if (status_q.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			want = status_q.pop_front();
			check_field("accepted", want.accepted, got.accepted);
			check_field("floor", want.floor, got.floor);
			check_field("load", want.load, got.load);
			check_field("car_state", want.car_state, got.car_state);
			check_field("arrived", want.arrived, got.arrived);
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	car_scoreboard sb;
	int            cycle_count;
	int            rx_mode = 0;
	int            rx_left = 0;

	elevator_car_controller #(
		.MAX_RIDERS (RIDERS),
		.TIME_BITS  (TIME_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: holds a stall mode for a random stretch, from always ready
	// through to long back-pressure, so stalls land on every phase of the work.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
		0:       out_ready <= 1'b1;
		1:       out_ready <= ($urandom_range(0, 3) != 0);
		2:       out_ready <= ($urandom_range(0, 3) == 0);
		default: out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Result monitor: values seen here are those that held just before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status(out_item);
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic in_item_t make_item(req_type_t r, logic [FLOOR_W-1:0] tgt,
			car_state_t ns, logic [ELAPSED_W-1:0] el);
		in_item_t it;
		it.req_type     = r;
		it.target_floor = tgt;
		it.new_state    = ns;
		it.elapsed      = el;
		return it;
	endfunction

	// Elapsed ticks, mostly around the limit in force so timers actually fire.
	function automatic logic [ELAPSED_W-1:0] random_ticks(int scale);
		int span;
		span = 2 * scale;
		if (span > 65535)
			span = 65535;
		case ($urandom_range(0, 9))
		0:             return '0;
		1:             return '1;
		2, 3, 4, 5, 6: return ELAPSED_W'($urandom_range(0, span));
		default:       return ELAPSED_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly sensible requests (riders for reachable floors, up/down moves,
	// timed advances); the remainder is left as fully random noise.
	function automatic in_item_t random_request();
		in_item_t it;
		int       pick;
		it   = IN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			it.req_type = REQ_ADD;
			if ($urandom_range(0, 9) < 7)
				it.target_floor = FLOOR_W'($urandom_range(FLOOR_GROUND, sb.top_floor));
		end else if (pick < 43) begin
			it.req_type = REQ_SET_STATE;
			if ($urandom_range(0, 3) != 0)
				it.new_state = 2'($urandom_range(CS_UP, CS_DOWN));
		end else if (pick < 58) begin
			it.req_type = REQ_IDLE_ADV;
			it.elapsed  = random_ticks(sb.idle_limit);
		end else if (pick < 95) begin
			it.req_type = REQ_MOVE_ADV;
			it.elapsed  = random_ticks(sb.travel_time);
		end
		return it;
	endfunction

	// Presents one item and waits for its handshake; valid is left high so a
	// following item goes out back to back.
	task automatic send_item(input in_item_t it);
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Register settings per phase: the two extremes first, then mid-range
	// and random ones. Only called with the car idle and nothing in flight.
	task automatic apply_setting(input int p);
		logic [CFG_DATA_W-1:0] cap, top, idle, trav;
		case (p)
		0: begin cap = 1;  top = 2;  idle = 1;     trav = 1;     end
		1: begin cap = 16; top = 63; idle = 65535; trav = 65535; end
		2: begin cap = 4;  top = 8;  idle = 50;    trav = 20;    end
		3: begin cap = 16; top = 63; idle = 300;   trav = 7;     end
		4: begin cap = 12; top = 5;  idle = 1000;  trav = 100;   end
		default: begin
			cap  = CFG_DATA_W'($urandom_range(1, 16));
			top  = CFG_DATA_W'($urandom_range(2, 63));
			idle = CFG_DATA_W'($urandom_range(1, 2000));
			trav = CFG_DATA_W'($urandom_range(1, 300));
		end
		endcase
		write_reg(CFG_CAPACITY, cap);
		write_reg(CFG_TOP_FLOOR, top);
		write_reg(CFG_IDLE_LIMIT, idle);
		write_reg(CFG_TRAVEL_TIME, trav);
		cfg_we <= 1'b0;
	endtask

	// Directed run at reset settings (capacity 8, top 16, idle 1000, travel 100).
	task automatic run_directed();
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'd0));      // no tick
		send_item(make_item(REQ_IDLE_ADV, 6'd0, CS_IDLE, 16'd999));    // just short
		send_item(make_item(REQ_IDLE_ADV, 6'd0, CS_IDLE, 16'd1));      // limit on ground floor
		send_item(make_item(REQ_ADD, 6'd3, CS_IDLE, 16'd0));
		send_item(make_item(REQ_ADD, 6'd0, CS_IDLE, 16'd0));           // floor 0, never leaves
		send_item(make_item(REQ_ADD, 6'd63, CS_IDLE, 16'd0));          // above top floor
		send_item(make_item(REQ_SET_STATE, 6'd0, CS_UP, 16'd0));
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'hFFFF));   // to floor 2
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'd100));    // floor 3, drop
		send_item(make_item(REQ_SET_STATE, 6'd0, CS_IDLE, 16'd0));
		send_item(make_item(REQ_IDLE_ADV, 6'd0, CS_IDLE, 16'hFFFF));   // heads down
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'd100));
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'd100));
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'd100));    // clamp at floor 1
		send_item(make_item(REQ_SET_STATE, 6'd0, CS_STOPPED, 16'd0));
		send_item(make_item(REQ_IDLE_ADV, 6'd0, CS_IDLE, 16'd500));    // ignored, not idle
		send_item(make_item(REQ_ADD, 6'd1, CS_IDLE, 16'd0));
		for (int i = 0; i < 5; i++)
			send_item(make_item(REQ_ADD, 6'd2, CS_IDLE, 16'd0));
		send_item(make_item(REQ_ADD, 6'd5, CS_IDLE, 16'd0));           // refused, car already full
		send_item(make_item(REQ_ADD, 6'd6, CS_IDLE, 16'd0));           // refused, full
		send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'd100));    // stopped car drops
		send_item(make_item(REQ_SET_STATE, 6'd0, CS_IDLE, 16'd0));
		in_valid <= 1'b0;
	endtask

	// Random items in bursts of random length; gaps sometimes skipped so
	// long back-to-back stretches occur too.
	task automatic run_random(input int count);
		int sent, burst, gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_item(random_request());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			apply_setting(p);
			// start each phase moving up: catches a car above a lowered top floor
			send_item(make_item(REQ_SET_STATE, 6'd0, CS_UP, 16'd0));
			send_item(make_item(REQ_MOVE_ADV, 6'd0, CS_IDLE, 16'hFFFF));
			run_random(ITEMS_PER_PHASE);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* elevator_car_controller.f */
rtl/ecc_pkg.sv
rtl/ecc_ram.sv
rtl/ecc_tmr_unit.sv
rtl/elevator_car_controller.sv
tb/tb_elevator_car_controller.sv
